// File: rtl/core/sot_pkg.sv
// Package for the shape overlap test pipeline.
// Holds the pair-type codes, the per-stage flag struct and the work width helper.
// No dependencies.
package sot_pkg;

  // Default field widths of the coordinate and size inputs.
  localparam int unsigned CoordBitsDef = 20;
  localparam int unsigned SizeBitsDef  = 16;

  // Pair type carried by each transaction.
  typedef enum logic [1:0] {
    MODE_RECT_RECT     = 2'd0,
    MODE_RECT_CIRCLE   = 2'd1,
    MODE_CIRCLE_CIRCLE = 2'd2
  } mode_e;

  // Control and partial results that travel alongside the data path.
  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  rr_hit;   // rectangle pair overlaps on both axes
    logic  near;     // squared distance below squared threshold
    logic  band_x;   // circle centre strictly inside the rectangle span in x
    logic  band_y;   // circle centre strictly inside the rectangle span in y
    logic  hit_x;    // side check along x succeeds
    logic  hit_y;    // side check along y succeeds
  } sot_flags_t;

  // Signed width of the doubled-domain differences, with headroom for
  // adding or subtracting a size or a doubled radius.
  function automatic int unsigned sot_work_width(int unsigned coord_bits,
                                                 int unsigned size_bits);
    int unsigned wider;
    wider = (coord_bits > size_bits) ? coord_bits : size_bits;
    return wider + 3;
  endfunction

endpackage

// File: rtl/core/sot_in_if.sv
// Input channel of the shape overlap test: valid/ready plus one shape pair.
// Depends on sot_pkg for the default widths.
interface sot_in_if
  import sot_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic [SIZE_BITS-1:0]         a_width;
  logic [SIZE_BITS-1:0]         a_height;
  logic [SIZE_BITS-1:0]         a_radius;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic [SIZE_BITS-1:0]         b_width;
  logic [SIZE_BITS-1:0]         b_height;
  logic [SIZE_BITS-1:0]         b_radius;

  modport source (
    output valid, mode, a_x, a_y, a_width, a_height, a_radius,
           b_x, b_y, b_width, b_height, b_radius,
    input  ready
  );

  modport sink (
    input  valid, mode, a_x, a_y, a_width, a_height, a_radius,
           b_x, b_y, b_width, b_height, b_radius,
    output ready
  );
endinterface

// File: rtl/core/sot_out_if.sv
// Output channel of the shape overlap test: valid/ready plus the overlap flag.
// No dependencies.
interface sot_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (
    output valid, overlap,
    input  ready
  );

  modport sink (
    input  valid, overlap,
    output ready
  );
endinterface

// File: rtl/core/sot_diff.sv
// Stage 1 of the overlap pipeline: centre differences and threshold sums.
// Depends on sot_pkg.
module sot_diff
  import sot_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  localparam int unsigned DW        = sot_work_width(COORD_BITS, SIZE_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [1:0]                   mode_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic [SIZE_BITS-1:0]         a_width_i,
  input  logic [SIZE_BITS-1:0]         a_height_i,
  input  logic [SIZE_BITS-1:0]         a_radius_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic [SIZE_BITS-1:0]         b_width_i,
  input  logic [SIZE_BITS-1:0]         b_height_i,
  input  logic [SIZE_BITS-1:0]         b_radius_i,
  output logic signed [DW-1:0]         dx_o,
  output logic signed [DW-1:0]         dy_o,
  output logic [SIZE_BITS+1:0]         thr_o,
  output logic [SIZE_BITS:0]           sum_x_o,
  output logic [SIZE_BITS:0]           sum_y_o,
  output logic [SIZE_BITS-1:0]         aw_o,
  output logic [SIZE_BITS-1:0]         ah_o,
  output logic [SIZE_BITS:0]           r_o,
  output sot_flags_t                   flags_o
);

  logic signed [DW-1:0]  ax2, ay2, bx2, by2;
  logic signed [DW-1:0]  dx_d, dx_q, dy_d, dy_q;
  logic [SIZE_BITS-1:0]  side, thr_base_sel;
  logic [SIZE_BITS:0]    thr_base;
  logic [SIZE_BITS+1:0]  thr_d, thr_q;
  logic [SIZE_BITS:0]    sum_x_d, sum_x_q, sum_y_d, sum_y_q;
  logic [SIZE_BITS-1:0]  aw_q, ah_q;
  logic [SIZE_BITS:0]    r_q;
  sot_flags_t            flags_d, flags_q;

  // Doubled centres keep half sizes exact.
  assign ax2 = DW'($signed({a_x_i, 1'b0}));
  assign ay2 = DW'($signed({a_y_i, 1'b0}));
  assign bx2 = DW'($signed({b_x_i, 1'b0}));
  assign by2 = DW'($signed({b_y_i, 1'b0}));

  assign dx_d = ax2 - bx2;
  assign dy_d = ay2 - by2;

  // Threshold before squaring: twice (radius sum) for circles, twice
  // (larger side plus radius) for the quick reject of rectangle vs circle.
  assign side         = (a_width_i > a_height_i) ? a_width_i : a_height_i;
  assign thr_base_sel = (mode_e'(mode_i) == MODE_CIRCLE_CIRCLE) ? a_radius_i : side;
  assign thr_base     = (SIZE_BITS+1)'(thr_base_sel) + (SIZE_BITS+1)'(b_radius_i);
  assign thr_d        = {thr_base, 1'b0};

  // Rectangle pair limits per axis.
  assign sum_x_d = (SIZE_BITS+1)'(a_width_i) + (SIZE_BITS+1)'(b_width_i);
  assign sum_y_d = (SIZE_BITS+1)'(a_height_i) + (SIZE_BITS+1)'(b_height_i);

  // Flags start with only the transaction valid bit and the pair type.
  always_comb begin
    flags_d       = '0;
    flags_d.valid = valid_i;
    flags_d.mode  = mode_e'(mode_i);
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      thr_q   <= thr_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      aw_q    <= a_width_i;
      ah_q    <= a_height_i;
      r_q     <= {b_radius_i, 1'b0};
    end
  end

  assign dx_o    = dx_q;
  assign dy_o    = dy_q;
  assign thr_o   = thr_q;
  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;
  assign aw_o    = aw_q;
  assign ah_o    = ah_q;
  assign r_o     = r_q;
  assign flags_o = flags_q;

endmodule

// File: rtl/core/sot_square.sv
// Stage 2 of the overlap pipeline: squares of the distance terms, axis
// magnitudes and the rectangle pair test. Depends on sot_pkg.
module sot_square
  import sot_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  localparam int unsigned DW        = sot_work_width(COORD_BITS, SIZE_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic signed [DW-1:0]   dx_i,
  input  logic signed [DW-1:0]   dy_i,
  input  logic [SIZE_BITS+1:0]   thr_i,
  input  logic [SIZE_BITS:0]     sum_x_i,
  input  logic [SIZE_BITS:0]     sum_y_i,
  input  logic [SIZE_BITS-1:0]   aw_i,
  input  logic [SIZE_BITS-1:0]   ah_i,
  input  logic [SIZE_BITS:0]     r_i,
  input  sot_flags_t             flags_i,
  output logic [DW-2:0]          tx_o,
  output logic [DW-2:0]          ty_o,
  output logic [2*DW-1:0]        dx2_o,
  output logic [2*DW-1:0]        dy2_o,
  output logic [2*SIZE_BITS+3:0] thr2_o,
  output logic [2*SIZE_BITS+1:0] r2_o,
  output logic [SIZE_BITS-1:0]   aw_o,
  output logic [SIZE_BITS-1:0]   ah_o,
  output logic [SIZE_BITS:0]     r_o,
  output sot_flags_t             flags_o
);

  logic [DW-1:0]          dx_abs, dy_abs;
  logic [DW-2:0]          tx_d, tx_q, ty_d, ty_q;
  logic signed [2*DW-1:0] dx2_s, dy2_s;
  logic [2*DW-1:0]        dx2_q, dy2_q;
  logic [2*SIZE_BITS+3:0] thr2_d, thr2_q;
  logic [2*SIZE_BITS+1:0] r2_d, r2_q;
  logic [SIZE_BITS-1:0]   aw_q, ah_q;
  logic [SIZE_BITS:0]     r_q;
  sot_flags_t             flags_d, flags_q;

  // Axis magnitudes; the differences never reach the most negative code.
  assign dx_abs = dx_i[DW-1] ? DW'(-dx_i) : DW'(dx_i);
  assign dy_abs = dy_i[DW-1] ? DW'(-dy_i) : DW'(dy_i);
  assign tx_d   = dx_abs[DW-2:0];
  assign ty_d   = dy_abs[DW-2:0];

  // Squares for the distance tests.
  assign dx2_s  = dx_i * dx_i;
  assign dy2_s  = dy_i * dy_i;
  assign thr2_d = (2*SIZE_BITS+4)'(thr_i) * (2*SIZE_BITS+4)'(thr_i);
  assign r2_d   = (2*SIZE_BITS+2)'(r_i) * (2*SIZE_BITS+2)'(r_i);

  // Rectangle pair: strict centre distance against summed half sizes.
  always_comb begin
    flags_d        = flags_i;
    flags_d.rr_hit = (tx_d < (DW-1)'(sum_x_i)) && (ty_d < (DW-1)'(sum_y_i));
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx_q   <= tx_d;
      ty_q   <= ty_d;
      dx2_q  <= dx2_s;
      dy2_q  <= dy2_s;
      thr2_q <= thr2_d;
      r2_q   <= r2_d;
      aw_q   <= aw_i;
      ah_q   <= ah_i;
      r_q    <= r_i;
    end
  end

  assign tx_o    = tx_q;
  assign ty_o    = ty_q;
  assign dx2_o   = dx2_q;
  assign dy2_o   = dy2_q;
  assign thr2_o  = thr2_q;
  assign r2_o    = r2_q;
  assign aw_o    = aw_q;
  assign ah_o    = ah_q;
  assign r_o     = r_q;
  assign flags_o = flags_q;

endmodule

// File: rtl/core/sot_reduce.sv
// Stage 3 of the overlap pipeline: distance threshold compare, span checks
// and the corner and side offsets. Depends on sot_pkg.
module sot_reduce
  import sot_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  localparam int unsigned DW        = sot_work_width(COORD_BITS, SIZE_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [DW-2:0]          tx_i,
  input  logic [DW-2:0]          ty_i,
  input  logic [2*DW-1:0]        dx2_i,
  input  logic [2*DW-1:0]        dy2_i,
  input  logic [2*SIZE_BITS+3:0] thr2_i,
  input  logic [2*SIZE_BITS+1:0] r2_i,
  input  logic [SIZE_BITS-1:0]   aw_i,
  input  logic [SIZE_BITS-1:0]   ah_i,
  input  logic [SIZE_BITS:0]     r_i,
  input  sot_flags_t             flags_i,
  output logic signed [DW-1:0]   cx_o,
  output logic signed [DW-1:0]   cy_o,
  output logic signed [DW-1:0]   ex_o,
  output logic signed [DW-1:0]   ey_o,
  output logic [2*SIZE_BITS+1:0] r2_o,
  output logic [SIZE_BITS-1:0]   aw_o,
  output logic [SIZE_BITS-1:0]   ah_o,
  output sot_flags_t             flags_o
);

  logic [2*DW:0]          dist2;
  logic signed [DW-1:0]   tx_s, ty_s, aw_s, ah_s, r_s;
  logic signed [DW-1:0]   cx_d, cx_q, cy_d, cy_q, ex_d, ex_q, ey_d, ey_q;
  logic [2*SIZE_BITS+1:0] r2_q;
  logic [SIZE_BITS-1:0]   aw_q, ah_q;
  sot_flags_t             flags_d, flags_q;

  // Squared centre distance against the squared threshold.
  assign dist2 = (2*DW+1)'(dx2_i) + (2*DW+1)'(dy2_i);

  // Operands as non-negative signed values for the offset subtractions.
  assign tx_s = $signed({1'b0, tx_i});
  assign ty_s = $signed({1'b0, ty_i});
  assign aw_s = $signed({{(DW-SIZE_BITS){1'b0}}, aw_i});
  assign ah_s = $signed({{(DW-SIZE_BITS){1'b0}}, ah_i});
  assign r_s  = $signed({{(DW-SIZE_BITS-1){1'b0}}, r_i});

  // Offset from the facing corner, and from the near circle extreme; both
  // are symmetric in the side on which the circle lies.
  assign cx_d = tx_s - aw_s;
  assign cy_d = ty_s - ah_s;
  assign ex_d = tx_s - r_s;
  assign ey_d = ty_s - r_s;

  always_comb begin
    flags_d        = flags_i;
    flags_d.near   = dist2 < (2*DW+1)'(thr2_i);
    flags_d.band_x = tx_i < (DW-1)'(aw_i);
    flags_d.band_y = ty_i < (DW-1)'(ah_i);
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      ex_q <= ex_d;
      ey_q <= ey_d;
      r2_q <= r2_i;
      aw_q <= aw_i;
      ah_q <= ah_i;
    end
  end

  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign r2_o    = r2_q;
  assign aw_o    = aw_q;
  assign ah_o    = ah_q;
  assign flags_o = flags_q;

endmodule

// File: rtl/core/sot_corner.sv
// Stage 4 of the overlap pipeline: squares of the corner offsets and the
// per-axis side checks. Depends on sot_pkg.
module sot_corner
  import sot_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  localparam int unsigned DW        = sot_work_width(COORD_BITS, SIZE_BITS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic signed [DW-1:0]   cx_i,
  input  logic signed [DW-1:0]   cy_i,
  input  logic signed [DW-1:0]   ex_i,
  input  logic signed [DW-1:0]   ey_i,
  input  logic [2*SIZE_BITS+1:0] r2_i,
  input  logic [SIZE_BITS-1:0]   aw_i,
  input  logic [SIZE_BITS-1:0]   ah_i,
  input  sot_flags_t             flags_i,
  output logic [2*DW-1:0]        cx2_o,
  output logic [2*DW-1:0]        cy2_o,
  output logic [2*SIZE_BITS+1:0] r2_o,
  output sot_flags_t             flags_o
);

  logic signed [2*DW-1:0] cx2_s, cy2_s;
  logic [2*DW-1:0]        cx2_q, cy2_q;
  logic [DW-1:0]          ex_abs, ey_abs;
  logic [2*SIZE_BITS+1:0] r2_q;
  sot_flags_t             flags_d, flags_q;

  // Squared distance terms from the facing corner.
  assign cx2_s = cx_i * cx_i;
  assign cy2_s = cy_i * cy_i;

  // Side check: the circle extreme nearest the rectangle lies within its span.
  assign ex_abs = ex_i[DW-1] ? DW'(-ex_i) : DW'(ex_i);
  assign ey_abs = ey_i[DW-1] ? DW'(-ey_i) : DW'(ey_i);

  always_comb begin
    flags_d       = flags_i;
    flags_d.hit_x = ex_abs < DW'(aw_i);
    flags_d.hit_y = ey_abs < DW'(ah_i);
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx2_q <= cx2_s;
      cy2_q <= cy2_s;
      r2_q  <= r2_i;
    end
  end

  assign cx2_o   = cx2_q;
  assign cy2_o   = cy2_q;
  assign r2_o    = r2_q;
  assign flags_o = flags_q;

endmodule

// File: rtl/core/shape_overlap_test.sv
// Top level of the shape overlap test: four pipeline stages and the result
// register. Depends on sot_pkg, sot_in_if, sot_out_if and the sot_* stages.

// Tests one pair of 2D shapes per transaction (rectangle pair, rectangle
// against circle, or circle pair) and returns one overlap flag for each.
// A new transaction is accepted every clock cycle while input ready is high.
// The first of four data stages loads at the accepting clock edge (the
// squaring multipliers and the wide distance compares each get a stage of
// their own), and the output register follows the last one and drives the
// result onto the output channel. Every stage advances independently,
// so empty stages fill even while a result waits to be taken, and input
// ready drops only when all stages hold data and the output is stalled.
// Touching shapes do not overlap, and the unused pair type returns zero.
module shape_overlap_test
  import sot_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sot_in_if.sink         in_i,
  sot_out_if.source      out_o
);

  localparam int unsigned DW = sot_work_width(COORD_BITS, SIZE_BITS);

  // Stage 1 outputs.
  logic signed [DW-1:0]   s1_dx, s1_dy;
  logic [SIZE_BITS+1:0]   s1_thr;
  logic [SIZE_BITS:0]     s1_sum_x, s1_sum_y, s1_r;
  logic [SIZE_BITS-1:0]   s1_aw, s1_ah;
  sot_flags_t             s1_flags;
  // Stage 2 outputs.
  logic [DW-2:0]          s2_tx, s2_ty;
  logic [2*DW-1:0]        s2_dx2, s2_dy2;
  logic [2*SIZE_BITS+3:0] s2_thr2;
  logic [2*SIZE_BITS+1:0] s2_r2;
  logic [SIZE_BITS-1:0]   s2_aw, s2_ah;
  logic [SIZE_BITS:0]     s2_r;
  sot_flags_t             s2_flags;
  // Stage 3 outputs.
  logic signed [DW-1:0]   s3_cx, s3_cy, s3_ex, s3_ey;
  logic [2*SIZE_BITS+1:0] s3_r2;
  logic [SIZE_BITS-1:0]   s3_aw, s3_ah;
  sot_flags_t             s3_flags;
  // Stage 4 outputs.
  logic [2*DW-1:0]        s4_cx2, s4_cy2;
  logic [2*SIZE_BITS+1:0] s4_r2;
  sot_flags_t             s4_flags;

  logic        en1, en2, en3, en4, en_out;
  logic [2*DW:0] corner_dist2;
  logic        corner_hit, circle_hit, overlap_d;
  logic        out_valid_q, overlap_q;

  // Each stage loads when it is empty or its contents move on.
  assign en_out     = !out_valid_q || out_o.ready;
  assign en4        = !s4_flags.valid || en_out;
  assign en3        = !s3_flags.valid || en4;
  assign en2        = !s2_flags.valid || en3;
  assign en1        = !s1_flags.valid || en2;
  assign in_i.ready = en1;

  sot_diff #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en1),
    .valid_i    (in_i.valid),
    .mode_i     (in_i.mode),
    .a_x_i      (in_i.a_x),
    .a_y_i      (in_i.a_y),
    .a_width_i  (in_i.a_width),
    .a_height_i (in_i.a_height),
    .a_radius_i (in_i.a_radius),
    .b_x_i      (in_i.b_x),
    .b_y_i      (in_i.b_y),
    .b_width_i  (in_i.b_width),
    .b_height_i (in_i.b_height),
    .b_radius_i (in_i.b_radius),
    .dx_o       (s1_dx),
    .dy_o       (s1_dy),
    .thr_o      (s1_thr),
    .sum_x_o    (s1_sum_x),
    .sum_y_o    (s1_sum_y),
    .aw_o       (s1_aw),
    .ah_o       (s1_ah),
    .r_o        (s1_r),
    .flags_o    (s1_flags)
  );

  sot_square #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .dx_i    (s1_dx),
    .dy_i    (s1_dy),
    .thr_i   (s1_thr),
    .sum_x_i (s1_sum_x),
    .sum_y_i (s1_sum_y),
    .aw_i    (s1_aw),
    .ah_i    (s1_ah),
    .r_i     (s1_r),
    .flags_i (s1_flags),
    .tx_o    (s2_tx),
    .ty_o    (s2_ty),
    .dx2_o   (s2_dx2),
    .dy2_o   (s2_dy2),
    .thr2_o  (s2_thr2),
    .r2_o    (s2_r2),
    .aw_o    (s2_aw),
    .ah_o    (s2_ah),
    .r_o     (s2_r),
    .flags_o (s2_flags)
  );

  sot_reduce #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .tx_i    (s2_tx),
    .ty_i    (s2_ty),
    .dx2_i   (s2_dx2),
    .dy2_i   (s2_dy2),
    .thr2_i  (s2_thr2),
    .r2_i    (s2_r2),
    .aw_i    (s2_aw),
    .ah_i    (s2_ah),
    .r_i     (s2_r),
    .flags_i (s2_flags),
    .cx_o    (s3_cx),
    .cy_o    (s3_cy),
    .ex_o    (s3_ex),
    .ey_o    (s3_ey),
    .r2_o    (s3_r2),
    .aw_o    (s3_aw),
    .ah_o    (s3_ah),
    .flags_o (s3_flags)
  );

  sot_corner #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_corner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en4),
    .cx_i    (s3_cx),
    .cy_i    (s3_cy),
    .ex_i    (s3_ex),
    .ey_i    (s3_ey),
    .r2_i    (s3_r2),
    .aw_i    (s3_aw),
    .ah_i    (s3_ah),
    .flags_i (s3_flags),
    .cx2_o   (s4_cx2),
    .cy2_o   (s4_cy2),
    .r2_o    (s4_r2),
    .flags_o (s4_flags)
  );

  // Facing corner strictly inside the circle.
  assign corner_dist2 = (2*DW+1)'(s4_cx2) + (2*DW+1)'(s4_cy2);
  assign corner_hit   = corner_dist2 < (2*DW+1)'(s4_r2);

  // Rectangle vs circle after the quick reject: centre inside, corner
  // inside the circle, or a side check on either axis.
  assign circle_hit = s4_flags.near &&
                      ((s4_flags.band_x && s4_flags.band_y) || corner_hit ||
                       (s4_flags.band_y && s4_flags.hit_x) ||
                       (s4_flags.band_x && s4_flags.hit_y));

  // Pick the result for the pair type.
  always_comb begin
    unique case (s4_flags.mode)
      MODE_RECT_RECT:     overlap_d = s4_flags.rr_hit;
      MODE_RECT_CIRCLE:   overlap_d = circle_hit;
      MODE_CIRCLE_CIRCLE: overlap_d = s4_flags.near;
      default:            overlap_d = 1'b0;
    endcase
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= s4_flags.valid;
    end
  end

  // Output register: result bit.
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      overlap_q <= overlap_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.overlap = overlap_q;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for shape_overlap_test: directed and random shape pairs,
// predicted in the bench and compared against every overlap result.
// Depends on sot_pkg, sot_in_if, sot_out_if and the shape_overlap_test RTL.
module tb_top;
  import sot_pkg::*;

  typedef logic signed [CoordBitsDef-1:0] coord_t;
  typedef logic [SizeBitsDef-1:0]         size_t;

  // The fourth pair-type code has no meaning and must never report an overlap.
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam int RandomPairs = 850;
  localparam int HoldCycles  = 64;
  localparam int DrainCycles = 20;
  localparam int LimitCycles = 500000;
  localparam int SizeMax     = (1 << SizeBitsDef) - 1;

  typedef struct {
    logic [1:0] mode;
    coord_t     a_x;
    coord_t     a_y;
    size_t      a_width;
    size_t      a_height;
    size_t      a_radius;
    coord_t     b_x;
    coord_t     b_y;
    size_t      b_width;
    size_t      b_height;
    size_t      b_radius;
  } shape_pair_t;

  typedef struct {
    shape_pair_t pair;
    bit          overlap;
  } overlap_due_t;

  bit   clk_i;
  logic rst_ni;

  sot_in_if #(.COORD_BITS(CoordBitsDef), .SIZE_BITS(SizeBitsDef)) in_if ();
  sot_out_if out_if ();

  shape_overlap_test DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  shape_pair_t  pending_pairs[$];
  overlap_due_t overlap_expected[$];

  int  total_pairs;
  int  accepted_count;
  int  results_seen;
  int  overlap_hits;
  int  error_count;
  int  cycle_count;
  int  mode_count[4];
  bit  in_taken;
  bit  hold_off;
  int  send_gap;
  int  recv_stall;
  bit  sender_steady;
  bit  receiver_steady;

  // Clock with a period of 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Exact test dx^2 + dy^2 < s^2; every operand fits well inside 64 bits.
  function automatic bit within_dist(longint dx, longint dy, longint s);
    return (dx * dx + dy * dy) < (s * s);
  endfunction

  // Rectangle against circle, all values already doubled so half sizes are exact.
  function automatic bit rect_circle_overlap(longint ax, longint ay, longint aw, longint ah,
                                             longint bx, longint by, longint r);
    longint dx, dy, side, px, py, ex;
    dx   = ax - bx;
    dy   = ay - by;
    side = (aw > ah) ? aw : ah;
    // Far apart: no chance of contact.
    if (!within_dist(dx, dy, 2 * side + r)) return 1'b0;
    // Circle centre strictly inside the rectangle.
    if (abs_val(dx) < aw && abs_val(dy) < ah) return 1'b1;
    // Rectangle corner facing the circle centre; a level centre picks the greater side.
    px = (bx < ax) ? ax - aw : ax + aw;
    py = (by < ay) ? ay - ah : ay + ah;
    if (within_dist(px - bx, py - by, r)) return 1'b1;
    // Circle reaching across a side, checked per axis.
    if (by < ay + ah && by > ay - ah) begin
      ex = (bx < ax) ? bx + r : bx - r;
      if (abs_val(ex - ax) < aw) return 1'b1;
    end
    if (bx < ax + aw && bx > ax - aw) begin
      ex = (by < ay) ? by + r : by - r;
      if (abs_val(ex - ay) < ah) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected overlap flag of one shape pair.
  function automatic bit predict_overlap(shape_pair_t p);
    longint ax, ay, aw, ah, ar, bx, by, bw, bh, br;
    ax = 2 * longint'(p.a_x);
    ay = 2 * longint'(p.a_y);
    aw = longint'(p.a_width);
    ah = longint'(p.a_height);
    ar = 2 * longint'(p.a_radius);
    bx = 2 * longint'(p.b_x);
    by = 2 * longint'(p.b_y);
    bw = longint'(p.b_width);
    bh = longint'(p.b_height);
    br = 2 * longint'(p.b_radius);
    case (p.mode)
      MODE_RECT_RECT:     return abs_val(ax - bx) < aw + bw && abs_val(ay - by) < ah + bh;
      MODE_RECT_CIRCLE:   return rect_circle_overlap(ax, ay, aw, ah, bx, by, br);
      MODE_CIRCLE_CIRCLE: return within_dist(ax - bx, ay - by, ar + br);
      default:            return 1'b0;
    endcase
  endfunction

  function automatic shape_pair_t make_pair(logic [1:0] mode, int ax, int ay, int aw, int ah,
                                            int ar, int bx, int by, int bw, int bh, int br);
    shape_pair_t p;
    p.mode     = mode;
    p.a_x      = coord_t'(ax);
    p.a_y      = coord_t'(ay);
    p.a_width  = size_t'(aw);
    p.a_height = size_t'(ah);
    p.a_radius = size_t'(ar);
    p.b_x      = coord_t'(bx);
    p.b_y      = coord_t'(by);
    p.b_width  = size_t'(bw);
    p.b_height = size_t'(bh);
    p.b_radius = size_t'(br);
    return p;
  endfunction

  function automatic size_t clamp_size(int v);
    return size_t'((v < 0) ? 0 : ((v > SizeMax) ? SizeMax : v));
  endfunction

  // Sizes mostly small or moderate, with zero and the maximum often enough.
  function automatic size_t random_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return size_t'($urandom_range(0, 15));
      3, 4:    return size_t'($urandom_range(0, 255));
      5, 6:    return size_t'($urandom_range(0, 4095));
      default: return size_t'($urandom);
    endcase
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 2)) - 1;
  endfunction

  // Random pair: unrelated positions, nearby shapes, or shapes placed at contact.
  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int span, k, sx, sy, total_r, lo_r, hi_r;
    p.mode     = ($urandom_range(0, 31) == 0) ? ModeUnused : 2'($urandom_range(0, 2));
    p.a_x      = coord_t'($urandom);
    p.a_y      = coord_t'($urandom);
    p.a_width  = random_size();
    p.a_height = random_size();
    p.a_radius = random_size();
    p.b_x      = coord_t'($urandom);
    p.b_y      = coord_t'($urandom);
    p.b_width  = random_size();
    p.b_height = random_size();
    p.b_radius = random_size();
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0, 1: begin
        // Keep the unrelated positions.
      end
      8, 9: begin
        case (p.mode)
          MODE_RECT_RECT: begin
            // Equal parity makes the half-size sum a whole number, so edges can touch.
            p.b_width[0]  = p.a_width[0];
            p.b_height[0] = p.a_height[0];
            p.b_x = coord_t'(int'(p.a_x) + sx * ((int'(p.a_width) + int'(p.b_width)) / 2));
            p.b_y = coord_t'(int'(p.a_y) + sy * int'($urandom_range(0,
                        (int'(p.a_height) + int'(p.b_height)) / 2)));
          end
          MODE_RECT_CIRCLE: begin
            p.a_width[0]  = 1'b0;
            p.a_height[0] = 1'b0;
            if ($urandom_range(0, 1)) begin
              // Circle resting against a side.
              p.b_x = coord_t'(int'(p.a_x) + sx * (int'(p.a_width) / 2 + int'(p.b_radius))
                               + jitter());
              p.b_y = coord_t'(int'(p.a_y) + int'($urandom_range(0, p.a_height))
                               - int'(p.a_height) / 2);
            end else begin
              // Circle resting on a corner along a 3-4-5 triangle.
              k = $urandom_range(0, SizeMax / 5);
              p.b_radius = clamp_size(5 * k + jitter());
              p.b_x = coord_t'(int'(p.a_x) + sx * (int'(p.a_width) / 2 + 3 * k));
              p.b_y = coord_t'(int'(p.a_y) + sy * (int'(p.a_height) / 2 + 4 * k));
            end
          end
          default: begin
            // Two circles at a 3-4-5 distance with radii summing to the distance.
            k       = $urandom_range(0, 2 * SizeMax / 5);
            total_r = 5 * k;
            lo_r    = (total_r > SizeMax) ? total_r - SizeMax : 0;
            hi_r    = (total_r > SizeMax) ? SizeMax : total_r;
            p.a_radius = size_t'($urandom_range(lo_r, hi_r));
            p.b_radius = clamp_size(total_r - int'(p.a_radius) + jitter());
            p.b_x = coord_t'(int'(p.a_x) + sx * 3 * k);
            p.b_y = coord_t'(int'(p.a_y) + sy * 4 * k);
          end
        endcase
      end
      default: begin
        // Shape B within reach of shape A.
        span = (int'(p.a_width) + int'(p.b_width)) / 2 + int'(p.a_radius)
               + int'(p.b_radius) + 16;
        p.b_x = coord_t'(int'(p.a_x) + int'($urandom_range(0, 2 * span)) - span);
        span = (int'(p.a_height) + int'(p.b_height)) / 2 + int'(p.a_radius)
               + int'(p.b_radius) + 16;
        p.b_y = coord_t'(int'(p.a_y) + int'($urandom_range(0, 2 * span)) - span);
      end
    endcase
    return p;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input monitor: predict the result of every accepted transaction.
  always @(posedge clk_i) begin : pair_monitor
    shape_pair_t seen;
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen.mode     = in_if.mode;
      seen.a_x      = in_if.a_x;
      seen.a_y      = in_if.a_y;
      seen.a_width  = in_if.a_width;
      seen.a_height = in_if.a_height;
      seen.a_radius = in_if.a_radius;
      seen.b_x      = in_if.b_x;
      seen.b_y      = in_if.b_y;
      seen.b_width  = in_if.b_width;
      seen.b_height = in_if.b_height;
      seen.b_radius = in_if.b_radius;
      overlap_expected.push_back('{pair: seen, overlap: predict_overlap(seen)});
      mode_count[seen.mode]++;
      accepted_count++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Pair driver: present the next pending pair once the current one is taken.
  always @(negedge clk_i) begin : pair_driver
    shape_pair_t next_pair;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (send_gap > 0 && !hold_off) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_pairs.size() > 0) begin
        next_pair = pending_pairs.pop_front();
        in_if.mode     <= next_pair.mode;
        in_if.a_x      <= next_pair.a_x;
        in_if.a_y      <= next_pair.a_y;
        in_if.a_width  <= next_pair.a_width;
        in_if.a_height <= next_pair.a_height;
        in_if.a_radius <= next_pair.a_radius;
        in_if.b_x      <= next_pair.b_x;
        in_if.b_y      <= next_pair.b_y;
        in_if.b_width  <= next_pair.b_width;
        in_if.b_height <= next_pair.b_height;
        in_if.b_radius <= next_pair.b_radius;
        in_if.valid    <= 1'b1;
        if ($urandom_range(0, 63) == 0) sender_steady = !sender_steady;
        send_gap = sender_steady ? 0 : idle_length();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, steady stretches, and the long hold-off.
  always @(negedge clk_i) begin : result_ready
    if (!rst_ni || hold_off) begin
      out_if.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      out_if.ready <= 1'b0;
      recv_stall--;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) receiver_steady = !receiver_steady;
      if (!receiver_steady && $urandom_range(0, 2) == 0) recv_stall = idle_length();
    end
  end

  // Hold the output off for a long stretch twice so the pipeline fills and stalls.
  initial begin : long_hold
    wait (accepted_count >= 200);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
    wait (accepted_count >= 600);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Result checker: compare each overlap flag with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    overlap_due_t due;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (overlap_expected.size() == 0) begin
        error_count++;
        $display("%0t: result with no transaction pending, actual overlap %0b",
                 $time, out_if.overlap);
      end else begin
        due = overlap_expected.pop_front();
        overlap_hits += due.overlap;
        if (out_if.overlap !== due.overlap) begin
          error_count++;
          if (error_count <= 50)
            $display("%0t: mode %0d A(%0d,%0d w%0d h%0d r%0d) B(%0d,%0d w%0d h%0d r%0d): %s %0b, %s %0b",
                     $time, due.pair.mode, due.pair.a_x, due.pair.a_y, due.pair.a_width,
                     due.pair.a_height, due.pair.a_radius, due.pair.b_x, due.pair.b_y,
                     due.pair.b_width, due.pair.b_height, due.pair.b_radius,
                     "expected overlap", due.overlap, "actual", out_if.overlap);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, overlap_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    rst_ni          = 1'b0;
    hold_off        = 1'b0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = '0;
    in_if.a_x       = '0;
    in_if.a_y       = '0;
    in_if.a_width   = '0;
    in_if.a_height  = '0;
    in_if.a_radius  = '0;
    in_if.b_x       = '0;
    in_if.b_y       = '0;
    in_if.b_width   = '0;
    in_if.b_height  = '0;
    in_if.b_radius  = '0;
    out_if.ready    = 1'b0;

    // Rectangle pairs: touching and just overlapping edges, extremes, zero sizes.
    pending_pairs.push_back(make_pair(MODE_RECT_RECT, 0, 0, 32, 32, 0, 32, 0, 32, 32, 0));
    pending_pairs.push_back(make_pair(MODE_RECT_RECT, 0, 0, 32, 32, 0, 31, 0, 32, 32, 0));
    pending_pairs.push_back(make_pair(MODE_RECT_RECT, 0, 0, 32, 32, 0, 0, -32, 32, 32, 0));
    pending_pairs.push_back(make_pair(MODE_RECT_RECT, -524288, 524287, 65535, 65535, 65535,
                                      -524288, 524287, 65535, 65535, 65535));
    pending_pairs.push_back(make_pair(MODE_RECT_RECT, -524288, -524288, 65535, 65535, 0,
                                      524287, 524287, 65535, 65535, 0));
    pending_pairs.push_back(make_pair(MODE_RECT_RECT, 7, 7, 0, 0, 0, 7, 7, 0, 0, 0));
    // Rectangle against circle: each step of the test order.
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0,
                                      100000, 100000, 0, 0, 65535));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, 5, -5, 0, 0, 1));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, 20, 20, 0, 0, 6));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, 20, 20, 0, 0, 5));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, 20, 0, 0, 0, 5));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, 20, 0, 0, 0, 4));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, 0, -20, 0, 0, 5));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 0, 0, 32, 32, 0, -20, 0, 0, 0, 5));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 3, 3, 0, 0, 0, 3, 3, 0, 0, 1));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 3, 3, 0, 0, 0, 3, 3, 0, 0, 0));
    pending_pairs.push_back(make_pair(MODE_RECT_CIRCLE, 524287, -524288, 65535, 65535, 65535,
                                      524287, -524288, 65535, 65535, 65535));
    // Circle pairs: touching, just overlapping, extremes, zero and full radii.
    pending_pairs.push_back(make_pair(MODE_CIRCLE_CIRCLE, 0, 0, 0, 0, 20, 30, 40, 0, 0, 30));
    pending_pairs.push_back(make_pair(MODE_CIRCLE_CIRCLE, 0, 0, 0, 0, 20, 30, 40, 0, 0, 31));
    pending_pairs.push_back(make_pair(MODE_CIRCLE_CIRCLE, -524288, -524288, 0, 0, 65535,
                                      524287, 524287, 0, 0, 65535));
    pending_pairs.push_back(make_pair(MODE_CIRCLE_CIRCLE, 9, 9, 0, 0, 0, 9, 9, 0, 0, 0));
    pending_pairs.push_back(make_pair(MODE_CIRCLE_CIRCLE, 524287, 524287, 0, 0, 65535,
                                      524287, 524287, 0, 0, 65535));
    // Unused pair type with shapes that would overlap.
    pending_pairs.push_back(make_pair(ModeUnused, 0, 0, 32, 32, 32, 0, 0, 32, 32, 32));
    pending_pairs.push_back(make_pair(ModeUnused, -1, -1, 65535, 65535, 65535,
                                      -1, -1, 65535, 65535, 65535));
    for (int i = 0; i < RandomPairs; i++) pending_pairs.push_back(random_pair());
    total_pairs = pending_pairs.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_pairs) @(posedge clk_i);
    while (overlap_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d overlap results for %0d shape pairs, %0d of them overlapping.",
             results_seen, accepted_count, overlap_hits);
    $display("Pair mix: %0d rect-rect, %0d rect-circle, %0d circle-circle, %0d unused type.",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sot_pkg.sv
rtl/core/sot_in_if.sv
rtl/core/sot_out_if.sv
rtl/core/sot_diff.sv
rtl/core/sot_square.sv
rtl/core/sot_reduce.sv
rtl/core/sot_corner.sv
rtl/core/shape_overlap_test.sv
test/tb_top.sv
